FILE: rtl/core/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master byte controller package
// Shared types, bus phase codes, command codes and register map.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  localparam logic [7:0] PHASE_TICKS_RESET = 8'd8;

  typedef enum logic [0:0] {
    REG_PHASE_TICKS = 1'b0
  } reg_index_t;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_STOP  = 2'd3
  } command_t;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'd0,
    PH_ST_A   = 5'd1,
    PH_ST_B   = 5'd2,
    PH_WB_HI  = 5'd3,
    PH_WB_LO  = 5'd4,
    PH_WB_ACK = 5'd5,
    PH_WB_END = 5'd6,
    PH_RB_LO  = 5'd7,
    PH_RB_HI  = 5'd8,
    PH_RB_PRE = 5'd9,
    PH_RB_ACK = 5'd10,
    PH_RB_END = 5'd11,
    PH_SP_A   = 5'd12,
    PH_SP_B   = 5'd13
  } phase_t;

  typedef struct packed {
    logic       tick;
    logic       cmd_valid;
    logic [1:0] command;
    logic [6:0] address;
    logic       read_not_write;
    logic [7:0] write_data;
    logic       last_byte;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       acked;
    logic       transaction_ok;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/i2cm_if.sv
// ----------------------------------------------------------------------------
// I2C master channel interfaces
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cm_item_if;
  logic       valid;
  logic       ready;
  logic       tick;
  logic       cmd_valid;
  logic [1:0] command;
  logic [6:0] address;
  logic       read_not_write;
  logic [7:0] write_data;
  logic       last_byte;
  logic       sda_in;

  modport source (
    output valid, tick, cmd_valid, command, address, read_not_write,
           write_data, last_byte, sda_in,
    input  ready
  );

  modport sink (
    input  valid, tick, cmd_valid, command, address, read_not_write,
           write_data, last_byte, sda_in,
    output ready
  );
endinterface

interface i2cm_result_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       acked;
  logic       transaction_ok;

  modport source (
    output valid, scl_out, sda_out, busy_res, done_res, read_data, acked,
           transaction_ok,
    input  ready
  );

  modport sink (
    input  valid, scl_out, sda_out, busy_res, done_res, read_data, acked,
           transaction_ok,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/i2cm_engine.sv
// ----------------------------------------------------------------------------
// I2C master bus phase engine
// Holds the bus state and advances it by one word per step.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_engine (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire i2cm_pkg::item_t  item,
  input  wire logic [7:0]       phase_ticks,
  output i2cm_pkg::result_t     result
);
  import i2cm_pkg::*;

  phase_t     phase, phase_next;
  logic [3:0] bit_count, bit_count_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [7:0] tick_count, tick_count_next;
  logic       scl_level, scl_level_next;
  logic       sda_level, sda_level_next;
  logic       address_acked, address_acked_next;
  logic       nack_seen, nack_seen_next;
  logic       data_acked_any, data_acked_any_next;
  logic       read_mode, read_mode_next;
  logic       final_read, final_read_next;
  logic       last_ack, last_ack_next;
  logic [7:0] read_hold, read_hold_next;
  logic       sending_address, sending_address_next;

  logic       done;
  logic       tok;
  logic [7:0] limit;
  logic [7:0] tick_inc;
  logic [3:0] bit_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      bit_count       <= '0;
      shift_byte      <= '0;
      tick_count      <= '0;
      scl_level       <= 1'b1;
      sda_level       <= 1'b1;
      address_acked   <= 1'b0;
      nack_seen       <= 1'b0;
      data_acked_any  <= 1'b0;
      read_mode       <= 1'b0;
      final_read      <= 1'b0;
      last_ack        <= 1'b0;
      read_hold       <= '0;
      sending_address <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      bit_count       <= bit_count_next;
      shift_byte      <= shift_byte_next;
      tick_count      <= tick_count_next;
      scl_level       <= scl_level_next;
      sda_level       <= sda_level_next;
      address_acked   <= address_acked_next;
      nack_seen       <= nack_seen_next;
      data_acked_any  <= data_acked_any_next;
      read_mode       <= read_mode_next;
      final_read      <= final_read_next;
      last_ack        <= last_ack_next;
      read_hold       <= read_hold_next;
      sending_address <= sending_address_next;
    end
  end

  assign limit    = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
  assign tick_inc = tick_count + 8'd1;
  assign bit_inc  = bit_count + 4'd1;

  always_comb begin
    phase_next           = phase;
    bit_count_next       = bit_count;
    shift_byte_next      = shift_byte;
    tick_count_next      = tick_count;
    scl_level_next       = scl_level;
    sda_level_next       = sda_level;
    address_acked_next   = address_acked;
    nack_seen_next       = nack_seen;
    data_acked_any_next  = data_acked_any;
    read_mode_next       = read_mode;
    final_read_next      = final_read;
    last_ack_next        = last_ack;
    read_hold_next       = read_hold;
    sending_address_next = sending_address;
    done                 = 1'b0;
    tok                  = 1'b0;

    if (phase == PH_IDLE) begin
      if (item.cmd_valid) begin
        tick_count_next = '0;
        case (command_t'(item.command))
          CMD_START: begin
            address_acked_next   = 1'b0;
            nack_seen_next       = 1'b0;
            data_acked_any_next  = 1'b0;
            read_mode_next       = item.read_not_write;
            sending_address_next = 1'b1;
            shift_byte_next      = {item.address, item.read_not_write};
            bit_count_next       = '0;
            sda_level_next       = 1'b0;
            phase_next           = PH_ST_A;
          end
          CMD_WRITE: begin
            if (!address_acked || nack_seen) begin
              last_ack_next = 1'b0;
              done          = 1'b1;
            end else begin
              sending_address_next = 1'b0;
              shift_byte_next      = item.write_data;
              bit_count_next       = '0;
              sda_level_next       = item.write_data[7];
              scl_level_next       = 1'b1;
              phase_next           = PH_WB_HI;
            end
          end
          CMD_READ: begin
            if (!address_acked) begin
              done = 1'b1;
            end else begin
              final_read_next = item.last_byte;
              shift_byte_next = '0;
              bit_count_next  = '0;
              sda_level_next  = 1'b1;
              phase_next      = PH_RB_LO;
            end
          end
          default: begin
            scl_level_next = 1'b1;
            phase_next     = PH_SP_A;
          end
        endcase
      end
    end else if (item.tick) begin
      if (tick_inc >= limit) begin
        tick_count_next = '0;
        case (phase)
          PH_ST_A: begin
            scl_level_next = 1'b0;
            phase_next     = PH_ST_B;
          end
          PH_ST_B: begin
            sda_level_next = shift_byte[7];
            scl_level_next = 1'b1;
            phase_next     = PH_WB_HI;
          end
          PH_WB_HI: begin
            scl_level_next  = 1'b0;
            shift_byte_next = {shift_byte[6:0], 1'b0};
            bit_count_next  = bit_inc;
            phase_next      = PH_WB_LO;
          end
          PH_WB_LO: begin
            if (bit_count < 4'd8) begin
              sda_level_next = shift_byte[7];
              scl_level_next = 1'b1;
              phase_next     = PH_WB_HI;
            end else begin
              sda_level_next = 1'b1;
              scl_level_next = 1'b1;
              phase_next     = PH_WB_ACK;
            end
          end
          PH_WB_ACK: begin
            last_ack_next  = ~item.sda_in;
            scl_level_next = 1'b0;
            sda_level_next = 1'b0;
            phase_next     = PH_WB_END;
          end
          PH_WB_END: begin
            if (sending_address) begin
              address_acked_next = last_ack;
            end else if (last_ack) begin
              data_acked_any_next = 1'b1;
            end else begin
              nack_seen_next = 1'b1;
            end
            done       = 1'b1;
            phase_next = PH_IDLE;
          end
          PH_RB_LO: begin
            scl_level_next  = 1'b1;
            shift_byte_next = {shift_byte[6:0], item.sda_in};
            phase_next      = PH_RB_HI;
          end
          PH_RB_HI: begin
            scl_level_next = 1'b0;
            bit_count_next = bit_inc;
            phase_next     = (bit_inc >= 4'd8) ? PH_RB_PRE : PH_RB_LO;
          end
          PH_RB_PRE: begin
            sda_level_next = final_read;
            scl_level_next = 1'b1;
            phase_next     = PH_RB_ACK;
          end
          PH_RB_ACK: begin
            scl_level_next = 1'b0;
            sda_level_next = 1'b0;
            phase_next     = PH_RB_END;
          end
          PH_RB_END: begin
            read_hold_next = shift_byte;
            done           = 1'b1;
            phase_next     = PH_IDLE;
          end
          PH_SP_A: begin
            sda_level_next = 1'b1;
            phase_next     = PH_SP_B;
          end
          PH_SP_B: begin
            tok        = read_mode ? address_acked
                                   : (address_acked && !nack_seen && data_acked_any);
            done       = 1'b1;
            phase_next = PH_IDLE;
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end else begin
        tick_count_next = tick_inc;
      end
    end

    result.scl_out        = scl_level_next;
    result.sda_out        = sda_level_next;
    result.busy_res       = (phase_next != PH_IDLE);
    result.done_res       = done;
    result.read_data      = read_hold_next;
    result.acked          = last_ack_next;
    result.transaction_ok = tok;
  end

endmodule

`default_nettype wire

FILE: rtl/core/i2c_master_byte_controller.sv
// Each command word passes through the input register, then the result register.
// Throughput: one word per cycle while the sink takes results; when the sink
// stalls, the input register can still take one word before req.ready drops.
// Reset (rst, synchronous): bus lines released, phase idle, flags cleared,
// phase_ticks back to 8.
// ----------------------------------------------------------------------------
// I2C master byte controller
// Tick-paced I2C master with an APB register port and word channels.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_byte_controller (
  input  wire logic                             clk,
  input  wire logic                             rst,
  i2cm_item_if.sink                             req,
  i2cm_result_if.source                         rsp,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [i2cm_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [i2cm_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [i2cm_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                  pready
);
  import i2cm_pkg::*;

  logic [7:0] phase_ticks_q;
  item_t      item_q;
  logic       item_valid;
  result_t    result;
  result_t    res_q;
  logic       res_valid;
  logic       step;
  logic       cfg_write;
  reg_index_t cfg_index;

  assign cfg_index   = reg_index_t'(paddr[APB_ADDR_W-1]);
  assign pready      = 1'b1;
  assign cfg_write   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks_q <= PHASE_TICKS_RESET;
    end else if (cfg_write && (cfg_index == REG_PHASE_TICKS)) begin
      phase_ticks_q <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_index)
      REG_PHASE_TICKS: prdata = {{(APB_DATA_W-8){1'b0}}, phase_ticks_q};
      default:         prdata = '0;
    endcase
  end

  assign step      = item_valid && (!res_valid || rsp.ready);
  assign req.ready = !item_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req.ready) begin
      item_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item_q.tick           <= req.tick;
      item_q.cmd_valid      <= req.cmd_valid;
      item_q.command        <= req.command;
      item_q.address        <= req.address;
      item_q.read_not_write <= req.read_not_write;
      item_q.write_data     <= req.write_data;
      item_q.last_byte      <= req.last_byte;
      item_q.sda_in         <= req.sda_in;
    end
  end

  i2cm_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .item        (item_q),
    .phase_ticks (phase_ticks_q),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= result;
    end
  end

  assign rsp.valid          = res_valid;
  assign rsp.scl_out        = res_q.scl_out;
  assign rsp.sda_out        = res_q.sda_out;
  assign rsp.busy_res       = res_q.busy_res;
  assign rsp.done_res       = res_q.done_res;
  assign rsp.read_data      = res_q.read_data;
  assign rsp.acked          = res_q.acked;
  assign rsp.transaction_ok = res_q.transaction_ok;

endmodule

`default_nettype wire

FILE: test/i2c_master_byte_controller_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C master byte controller checker
// Watches the command and result channels and the register port, keeps a
// cycle-true model of the bus sequencer, and compares every result word
// field by field against the oldest predicted word.
// ----------------------------------------------------------------------------

module i2c_master_byte_controller_check import i2cm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  i2cm_item_if                  req,
  i2cm_result_if                rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic                  pready,
  output int                    errors,
  output int                    pending
);

  logic [7:0] ticks_per_phase;
  phase_t     bus_phase;
  logic [3:0] bit_count;
  logic [7:0] shift_byte;
  logic [7:0] tick_count;
  logic       scl_level;
  logic       sda_level;
  logic       addr_acked;
  logic       nack_seen;
  logic       data_acked_any;
  logic       read_mode;
  logic       final_read;
  logic       last_ack;
  logic [7:0] read_hold;
  logic       sending_addr;

  result_t bus_results_due[$];

  function automatic void clear_state();
    ticks_per_phase = PHASE_TICKS_RESET;
    bus_phase = PH_IDLE;
    bit_count = '0;
    shift_byte = '0;
    tick_count = '0;
    scl_level = 1'b1;
    sda_level = 1'b1;
    addr_acked = 1'b0;
    nack_seen = 1'b0;
    data_acked_any = 1'b0;
    read_mode = 1'b0;
    final_read = 1'b0;
    last_ack = 1'b0;
    read_hold = '0;
    sending_addr = 1'b0;
  endfunction

  function automatic void drive_bit();
    sda_level = shift_byte[7];
    scl_level = 1'b1;
    bus_phase = PH_WB_HI;
  endfunction

  function automatic result_t bus_step(input item_t w);
    result_t    r;
    logic       done;
    logic       ok;
    logic [7:0] limit;
    logic [7:0] nxt;
    done = 1'b0;
    ok = 1'b0;
    if (bus_phase == PH_IDLE) begin
      if (w.cmd_valid) begin
        tick_count = '0;
        case (command_t'(w.command))
          CMD_START: begin
            addr_acked = 1'b0;
            nack_seen = 1'b0;
            data_acked_any = 1'b0;
            read_mode = w.read_not_write;
            sending_addr = 1'b1;
            shift_byte = {w.address, w.read_not_write};
            bit_count = '0;
            sda_level = 1'b0;
            bus_phase = PH_ST_A;
          end
          CMD_WRITE: begin
            if (!addr_acked || nack_seen) begin
              last_ack = 1'b0;
              done = 1'b1;
            end else begin
              sending_addr = 1'b0;
              shift_byte = w.write_data;
              bit_count = '0;
              drive_bit();
            end
          end
          CMD_READ: begin
            if (!addr_acked) begin
              done = 1'b1;
            end else begin
              final_read = w.last_byte;
              shift_byte = '0;
              bit_count = '0;
              sda_level = 1'b1;
              bus_phase = PH_RB_LO;
            end
          end
          default: begin
            scl_level = 1'b1;
            bus_phase = PH_SP_A;
          end
        endcase
      end
    end else if (w.tick) begin
      limit = (ticks_per_phase == 8'd0) ? 8'd1 : ticks_per_phase;
      nxt = tick_count + 8'd1;
      if (nxt >= limit) begin
        tick_count = '0;
        case (bus_phase)
          PH_ST_A: begin
            scl_level = 1'b0;
            bus_phase = PH_ST_B;
          end
          PH_ST_B: drive_bit();
          PH_WB_HI: begin
            scl_level = 1'b0;
            shift_byte = shift_byte << 1;
            bit_count = bit_count + 4'd1;
            bus_phase = PH_WB_LO;
          end
          PH_WB_LO: begin
            if (bit_count < 4'd8) begin
              drive_bit();
            end else begin
              sda_level = 1'b1;
              scl_level = 1'b1;
              bus_phase = PH_WB_ACK;
            end
          end
          PH_WB_ACK: begin
            last_ack = !w.sda_in;
            scl_level = 1'b0;
            sda_level = 1'b0;
            bus_phase = PH_WB_END;
          end
          PH_WB_END: begin
            if (sending_addr) begin
              addr_acked = last_ack;
            end else if (last_ack) begin
              data_acked_any = 1'b1;
            end else begin
              nack_seen = 1'b1;
            end
            done = 1'b1;
            bus_phase = PH_IDLE;
          end
          PH_RB_LO: begin
            scl_level = 1'b1;
            shift_byte = {shift_byte[6:0], w.sda_in};
            bus_phase = PH_RB_HI;
          end
          PH_RB_HI: begin
            scl_level = 1'b0;
            bit_count = bit_count + 4'd1;
            bus_phase = (bit_count >= 4'd8) ? PH_RB_PRE : PH_RB_LO;
          end
          PH_RB_PRE: begin
            sda_level = final_read;
            scl_level = 1'b1;
            bus_phase = PH_RB_ACK;
          end
          PH_RB_ACK: begin
            scl_level = 1'b0;
            sda_level = 1'b0;
            bus_phase = PH_RB_END;
          end
          PH_RB_END: begin
            read_hold = shift_byte;
            done = 1'b1;
            bus_phase = PH_IDLE;
          end
          PH_SP_A: begin
            sda_level = 1'b1;
            bus_phase = PH_SP_B;
          end
          PH_SP_B: begin
            ok = read_mode ? addr_acked : (addr_acked && !nack_seen && data_acked_any);
            done = 1'b1;
            bus_phase = PH_IDLE;
          end
          default: bus_phase = PH_IDLE;
        endcase
      end else begin
        tick_count = nxt;
      end
    end
    r.scl_out = scl_level;
    r.sda_out = sda_level;
    r.busy_res = (bus_phase != PH_IDLE);
    r.done_res = done;
    r.read_data = read_hold;
    r.acked = last_ack;
    r.transaction_ok = ok;
    return r;
  endfunction

  task automatic flag(input string field, input int want, input int got);
    $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    errors++;
  endtask

  always @(posedge clk) begin : watch
    item_t   w;
    result_t want;
    result_t got;
    if (rst) begin
      clear_state();
      bus_results_due.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[APB_ADDR_W-1:2] == REG_PHASE_TICKS)
        ticks_per_phase = pwdata[7:0];
      if (req.valid && req.ready) begin
        w = {req.tick, req.cmd_valid, req.command, req.address, req.read_not_write,
             req.write_data, req.last_byte, req.sda_in};
        bus_results_due.push_back(bus_step(w));
      end
      if (rsp.valid && rsp.ready) begin
        got = {rsp.scl_out, rsp.sda_out, rsp.busy_res, rsp.done_res, rsp.read_data,
               rsp.acked, rsp.transaction_ok};
        if (bus_results_due.size() == 0) begin
          $display("%0t ns: result word with none expected, actual %0h", $time, got);
          errors++;
        end else begin
          want = bus_results_due.pop_front();
          if (got.scl_out !== want.scl_out) flag("scl_out", want.scl_out, got.scl_out);
          if (got.sda_out !== want.sda_out) flag("sda_out", want.sda_out, got.sda_out);
          if (got.busy_res !== want.busy_res) flag("busy_res", want.busy_res, got.busy_res);
          if (got.done_res !== want.done_res) flag("done_res", want.done_res, got.done_res);
          if (got.read_data !== want.read_data)
            flag("read_data", want.read_data, got.read_data);
          if (got.acked !== want.acked) flag("acked", want.acked, got.acked);
          if (got.transaction_ok !== want.transaction_ok)
            flag("transaction_ok", want.transaction_ok, got.transaction_ok);
        end
      end
    end
    pending <= bus_results_due.size();
  end

endmodule

FILE: test/i2c_master_byte_controller_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C master byte controller testbench
// Drives bus commands with a simulated target answering on SDA, across
// several phase tick settings, with random gaps and a long result stall.
// A side checker predicts every result word and counts mismatches.
// ----------------------------------------------------------------------------

module i2c_master_byte_controller_test;
  import i2cm_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEM_W = $bits(item_t);

  typedef struct {
    command_t   op;
    logic [6:0] addr;
    logic       rnw;
    logic [7:0] data;
    logic       last;
    logic       ack;
  } bus_cmd_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  int   fail_count;
  int   results_pending;
  int   words_taken = 0;
  int   done_seen = 0;
  int   done_target = 0;
  int   cycle_count = 0;
  logic last_busy = 1'b0;
  bit   no_gaps = 1'b0;

  i2cm_item_if   req ();
  i2cm_result_if rsp ();

  i2c_master_byte_controller dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  i2c_master_byte_controller_check check (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .pready  (pready),
    .errors  (fail_count),
    .pending (results_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      words_taken <= words_taken + 1;
      last_busy <= rsp.busy_res;
      if (rsp.done_res) done_seen <= done_seen + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // hold results back once for a long stretch so the block backs up
  initial begin : drain_results
    int  stall;
    bit  held;
    held = 1'b0;
    rsp.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && words_taken >= 100) begin
        held = 1'b1;
        rsp.ready <= 1'b0;
        repeat (60) @(posedge clk);
      end
      stall = pick_gap();
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
    end
  end

  function automatic bus_cmd_t cmd(input command_t op, input logic [6:0] addr,
                                   input logic rnw, input logic [7:0] data,
                                   input logic last, input logic ack);
    bus_cmd_t c;
    c.op = op;
    c.addr = addr;
    c.rnw = rnw;
    c.data = data;
    c.last = last;
    c.ack = ack;
    return c;
  endfunction

  function automatic bus_cmd_t rand_cmd(input command_t op);
    return cmd(op, 7'($urandom), 1'($urandom), 8'($urandom), 1'($urandom),
               $urandom_range(0, 9) != 0);
  endfunction

  // target answers ACK or NACK on SDA during address and write bytes
  function automatic item_t filler(input bus_cmd_t c);
    item_t w;
    w = item_t'(ITEM_W'($urandom));
    w.tick = ($urandom_range(0, 3) != 0);
    w.cmd_valid = last_busy && ($urandom_range(0, 15) == 0);
    if ((c.op == CMD_START || c.op == CMD_WRITE) && $urandom_range(0, 19) != 0)
      w.sda_in = !c.ack;
    return w;
  endfunction

  task automatic send_word(input item_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.tick <= w.tick;
    req.cmd_valid <= w.cmd_valid;
    req.command <= w.command;
    req.address <= w.address;
    req.read_not_write <= w.read_not_write;
    req.write_data <= w.write_data;
    req.last_byte <= w.last_byte;
    req.sda_in <= w.sda_in;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic run_cmd(input bus_cmd_t c);
    item_t w;
    done_target++;
    w = filler(c);
    w.cmd_valid = 1'b1;
    w.command = c.op;
    w.address = c.addr;
    w.read_not_write = c.rnw;
    w.write_data = c.data;
    w.last_byte = c.last;
    send_word(w);
    while (done_seen < done_target) send_word(filler(c));
  endtask

  task automatic run_random(input int count);
    bus_cmd_t c;
    int       issued;
    int       n;
    issued = 0;
    while (issued < count) begin
      if ($urandom_range(0, 99) < 85) begin
        c = rand_cmd(CMD_START);
        run_cmd(c);
        issued++;
        n = $urandom_range(0, 4);
        for (int k = 0; k < n; k++) begin
          c.op = c.rnw ? CMD_READ : CMD_WRITE;
          c.data = 8'($urandom);
          c.last = (k == n - 1) ^ ($urandom_range(0, 9) == 0);
          c.ack = ($urandom_range(0, 6) != 0);
          run_cmd(c);
          issued++;
        end
        c.op = CMD_STOP;
        run_cmd(c);
        issued++;
      end else begin
        run_cmd(rand_cmd(command_t'($urandom_range(0, 3))));
        issued++;
      end
    end
  endtask

  // drain results and let the block go idle
  task automatic settle();
    item_t w;
    req.valid <= 1'b0;
    forever begin
      @(posedge clk);
      if (results_pending == 0) begin
        if (!last_busy) break;
        w = filler(cmd(CMD_STOP, '0, 1'b0, '0, 1'b0, 1'b0));
        w.cmd_valid = 1'b0;
        w.tick = 1'b1;
        send_word(w);
        req.valid <= 1'b0;
      end
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [APB_DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin : stimulus
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    req.valid <= 1'b0;
    req.tick <= 1'b0;
    req.cmd_valid <= 1'b0;
    req.command <= CMD_START;
    req.address <= '0;
    req.read_not_write <= 1'b0;
    req.write_data <= '0;
    req.last_byte <= 1'b0;
    req.sda_in <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_cmd(cmd(CMD_STOP,  7'h00, 1'b0, 8'h00, 1'b0, 1'b1));
    run_cmd(cmd(CMD_WRITE, 7'h00, 1'b0, 8'hA5, 1'b0, 1'b1));
    run_cmd(cmd(CMD_READ,  7'h00, 1'b1, 8'h00, 1'b0, 1'b1));
    settle();
    write_reg(REG_PHASE_TICKS, 32'd1);
    run_cmd(cmd(CMD_START, 7'h7F, 1'b0, 8'h00, 1'b0, 1'b1));
    run_cmd(cmd(CMD_WRITE, 7'h7F, 1'b0, 8'hFF, 1'b0, 1'b1));
    run_cmd(cmd(CMD_STOP,  7'h7F, 1'b0, 8'h00, 1'b0, 1'b1));
    run_cmd(cmd(CMD_START, 7'h00, 1'b1, 8'hFF, 1'b0, 1'b1));
    run_cmd(cmd(CMD_READ,  7'h00, 1'b1, 8'h00, 1'b0, 1'b1));
    run_cmd(cmd(CMD_READ,  7'h00, 1'b1, 8'h00, 1'b1, 1'b1));
    run_cmd(cmd(CMD_STOP,  7'h00, 1'b1, 8'h00, 1'b0, 1'b1));
    run_cmd(cmd(CMD_START, 7'h55, 1'b0, 8'h00, 1'b0, 1'b0));
    run_cmd(cmd(CMD_WRITE, 7'h55, 1'b0, 8'h3C, 1'b0, 1'b1));
    run_cmd(cmd(CMD_STOP,  7'h55, 1'b0, 8'h00, 1'b0, 1'b1));
    run_cmd(cmd(CMD_START, 7'h2A, 1'b0, 8'h00, 1'b0, 1'b1));
    run_cmd(cmd(CMD_WRITE, 7'h2A, 1'b0, 8'h81, 1'b0, 1'b0));
    run_cmd(cmd(CMD_WRITE, 7'h2A, 1'b0, 8'h7E, 1'b0, 1'b1));
    run_cmd(cmd(CMD_STOP,  7'h2A, 1'b0, 8'h00, 1'b0, 1'b1));
    run_cmd(cmd(CMD_START, 7'h6B, 1'b1, 8'h00, 1'b0, 1'b0));
    run_cmd(cmd(CMD_READ,  7'h6B, 1'b1, 8'h00, 1'b1, 1'b1));
    run_cmd(cmd(CMD_STOP,  7'h6B, 1'b1, 8'h00, 1'b0, 1'b1));
    settle();
    write_reg(REG_PHASE_TICKS, 32'd0);
    run_cmd(cmd(CMD_START, 7'h11, 1'b0, 8'h00, 1'b0, 1'b1));
    run_cmd(cmd(CMD_STOP,  7'h11, 1'b0, 8'h00, 1'b0, 1'b1));
    settle();
    write_reg(REG_PHASE_TICKS, 32'd1);
    run_random(3);
    settle();
    no_gaps = 1'b1;
    run_random(3);
    settle();
    no_gaps = 1'b0;

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
